// ===== hdl/qph_pkg.sv =====
// Shared types, constants and helper function for the quadratic probe hash table.
package qph_pkg;

   localparam int TABLE_SIZE = 13;
   localparam int KEY_W = 31;
   localparam int SLOT_W = 4;
   localparam int CNT_W = 4;
   localparam int STATUS_W = 2;

   localparam logic [SLOT_W-1:0] TABLE_SIZE_S = SLOT_W'(TABLE_SIZE);
   localparam logic [CNT_W-1:0] LAST_PROBE = CNT_W'(TABLE_SIZE - 1);

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_SEARCH = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   // Write request into the slot store.
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] idx;
      logic [KEY_W-1:0]  key;
   } qph_wr_type;

   // Brings a value below twice the table size back into range.
   function automatic logic [SLOT_W-1:0] qph_wrap(input logic [SLOT_W:0] v);
      logic [SLOT_W:0] d;
      d = v - {1'b0, TABLE_SIZE_S};
      return (v >= {1'b0, TABLE_SIZE_S}) ? d[SLOT_W-1:0] : v[SLOT_W-1:0];
   endfunction

endpackage

// ===== hdl/qph_home.sv =====
// Iterative unit that reduces a key modulo the table size, one nibble per cycle.
module qph_home
   import qph_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [KEY_W-1:0]  key,
   output logic              done,
   output logic [SLOT_W-1:0] home
);

   localparam int NIB_COUNT = (KEY_W + 3) / 4;
   localparam int SHIFT_W = NIB_COUNT * 4;
   localparam int NCNT_W = $clog2(NIB_COUNT);
   localparam logic [NCNT_W-1:0] LAST_NIB = NCNT_W'(NIB_COUNT - 1);

   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [SLOT_W-1:0]  rem_ff, rem_in;
   logic [NCNT_W-1:0]  ncnt_ff, ncnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [7:0]         partial;

   // Restoring reduction of rem*16 + nibble, which stays below 16 times the table size.
   function automatic logic [SLOT_W-1:0] reduce(input logic [7:0] v);
      logic [7:0] t;
      t = v;
      for (int i = 3; i >= 0; i--) begin
         if (t >= (8'(TABLE_SIZE) << i)) begin
            t = t - (8'(TABLE_SIZE) << i);
         end
      end
      return t[SLOT_W-1:0];
   endfunction

   assign partial = {rem_ff, shift_ff[SHIFT_W-1 -: 4]};

   always_comb begin
      shift_in = shift_ff;
      rem_in = rem_ff;
      ncnt_in = ncnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         shift_in = SHIFT_W'(key);
         rem_in = '0;
         ncnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = reduce(partial);
         shift_in = shift_ff << 4;
         ncnt_in = ncnt_ff + 1'b1;
         if (ncnt_ff == LAST_NIB) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ncnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         ncnt_ff <= ncnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign home = rem_ff;

endmodule

// ===== hdl/qph_store.sv =====
// Slot store: occupied flags cleared at reset and the stored keys.
module qph_store
   import qph_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  qph_wr_type        wr,
   input  logic [SLOT_W-1:0] rd_idx,
   output logic              rd_occupied,
   output logic [KEY_W-1:0]  rd_key
);

   logic [TABLE_SIZE-1:0] occupied_ff;
   logic [KEY_W-1:0]      keys_ff [TABLE_SIZE];

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff <= '0;
      end else if (wr.en) begin
         occupied_ff[wr.idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         keys_ff[wr.idx] <= wr.key;
      end
   end

   assign rd_occupied = occupied_ff[rd_idx];
   assign rd_key = keys_ff[rd_idx];

endmodule

// ===== hdl/quadratic_probe_hash_table_top.sv =====
// Top level: probe sequencer of the quadratic probe hash table.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_command, req_key
//  rsp      out        rsp_valid/rsp_stall   rsp_status, rsp_slot, rsp_probes
//
// A transaction is accepted in ST_IDLE, passes through the nibble-serial home
// slot unit in ST_HASH, then probes the slot store in ST_PROBE (1 to 13 probes)
// until the result register is loaded. Reset clears all occupied
// flags at once; no clearing pass is needed. req_stall is high while a
// transaction is in progress, and the last probe waits while an earlier result
// is still stalled in the output register.
module quadratic_probe_hash_table_top
   import qph_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_command,
   input  logic [KEY_W-1:0]    req_key,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [CNT_W-1:0]    rsp_probes
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_PROBE
   } state_type;

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [SLOT_W-1:0]   home_ff, home_in;
   logic [SLOT_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SLOT_W-1:0]   sq_ff, sq_in;
   logic [SLOT_W-1:0]   inc_ff, inc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [CNT_W-1:0]    rsp_probes_ff, rsp_probes_in;

   logic                home_start;
   logic                home_done;
   logic [SLOT_W-1:0]   home_val;
   qph_wr_type          wr;
   logic                rd_occupied;
   logic [KEY_W-1:0]    rd_key;

   logic                out_free;
   logic                finish;
   status_type          fin_status;
   logic                next_odd;
   logic [SLOT_W-1:0]   sq_next;
   logic [SLOT_W-1:0]   inc_next;
   logic [SLOT_W-1:0]   offset_next;
   logic [SLOT_W-1:0]   pos_next;

   qph_home u_home (
      .clock (clock),
      .reset (reset),
      .start (home_start),
      .key   (req_key),
      .done  (home_done),
      .home  (home_val)
   );

   qph_store u_store (
      .clock       (clock),
      .reset       (reset),
      .wr          (wr),
      .rd_idx      (pos_ff),
      .rd_occupied (rd_occupied),
      .rd_key      (rd_key)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // The square grows by the next odd number each time an odd probe begins.
   assign next_odd = !cnt_ff[0];
   assign sq_next = next_odd ? qph_wrap({1'b0, sq_ff} + {1'b0, inc_ff}) : sq_ff;
   assign inc_next = next_odd ? qph_wrap({1'b0, inc_ff} + (SLOT_W + 1)'(2)) : inc_ff;
   assign offset_next = (next_odd || sq_next == '0) ? sq_next : (TABLE_SIZE_S - sq_next);
   assign pos_next = qph_wrap({1'b0, home_ff} + {1'b0, offset_next});

   always_comb begin
      finish = 1'b0;
      fin_status = STATUS_OK;
      if (cmd_ff == CMD_INSERT) begin
         if (!rd_occupied) begin
            finish = 1'b1;
         end else if (cnt_ff == LAST_PROBE) begin
            finish = 1'b1;
            fin_status = STATUS_FULL;
         end
      end else begin
         if (!rd_occupied || (cnt_ff != '0 && pos_ff == home_ff)) begin
            finish = 1'b1;
            fin_status = STATUS_MISS;
         end else if (rd_key == key_ff) begin
            finish = 1'b1;
         end else if (cnt_ff == LAST_PROBE) begin
            finish = 1'b1;
            fin_status = STATUS_MISS;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      key_in = key_ff;
      home_in = home_ff;
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      sq_in = sq_ff;
      inc_in = inc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_probes_in = rsp_probes_ff;
      home_start = 1'b0;
      wr = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = cmd_type'(req_command);
               key_in = req_key;
               home_start = 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (home_done) begin
               home_in = home_val;
               pos_in = home_val;
               cnt_in = '0;
               sq_in = '0;
               inc_in = SLOT_W'(1);
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (finish) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = fin_status;
                  rsp_slot_in = pos_ff;
                  rsp_probes_in = cnt_ff + 1'b1;
                  wr.en = (cmd_ff == CMD_INSERT) && !rd_occupied;
                  wr.idx = pos_ff;
                  wr.key = key_ff;
                  state_in = ST_IDLE;
               end
            end else begin
               pos_in = pos_next;
               sq_in = sq_next;
               inc_in = inc_next;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      home_ff <= home_in;
      pos_ff <= pos_in;
      cnt_ff <= cnt_in;
      sq_ff <= sq_in;
      inc_ff <= inc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_probes_ff <= rsp_probes_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot = rsp_slot_ff;
   assign rsp_probes = rsp_probes_ff;

   a_probes_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_probes != '0 && rsp_probes <= CNT_W'(TABLE_SIZE)))
      else $error("probe count out of range");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_slot < TABLE_SIZE_S))
      else $error("result slot out of range");

   a_write_on_insert: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == ST_PROBE && cmd_ff == CMD_INSERT && !rd_occupied))
      else $error("slot write outside an insert probe");

   a_home_in_hash: assert property (@(posedge clock) disable iff (reset)
      home_done |-> (state_ff == ST_HASH))
      else $error("home slot ready outside hashing");

endmodule
